>>> rtl/ifrd_pkg.sv
package ifrd_pkg;

   localparam int BYTE_W          = 8;
   localparam int KIND_W          = 3;
   localparam int PAYLOAD_COUNT_W = 13;
   localparam int CSR_INDEX_W     = 3;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_FLAG_BYTE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_BYTE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLAG_ESC_CODE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESC_ESC_CODE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_BYTE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFO_CTRL_SEQ0 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFO_CTRL_SEQ1 = 3'd6;

   localparam logic [BYTE_W-1:0] FLAG_BYTE_RST      = 8'd126;
   localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST    = 8'd125;
   localparam logic [BYTE_W-1:0] FLAG_ESC_CODE_RST  = 8'd94;
   localparam logic [BYTE_W-1:0] ESC_ESC_CODE_RST   = 8'd93;
   localparam logic [BYTE_W-1:0] ADDRESS_BYTE_RST   = 8'd3;
   localparam logic [BYTE_W-1:0] INFO_CTRL_SEQ0_RST = 8'd0;
   localparam logic [BYTE_W-1:0] INFO_CTRL_SEQ1_RST = 8'd64;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA      = 3'd0,
      KIND_GOOD      = 3'd1,
      KIND_BAD_CHECK = 3'd2,
      KIND_ESC_ERROR = 3'd3,
      KIND_OVERFLOW  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_HUNT = 3'd0,
      ST_FLAG = 3'd1,
      ST_ADDR = 3'd2,
      ST_CTRL = 3'd3,
      ST_INFO = 3'd4
   } frame_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] flag_byte;
      logic [BYTE_W-1:0] escape_byte;
      logic [BYTE_W-1:0] flag_esc_code;
      logic [BYTE_W-1:0] esc_esc_code;
      logic [BYTE_W-1:0] address_byte;
      logic [BYTE_W-1:0] info_ctrl_seq0;
      logic [BYTE_W-1:0] info_ctrl_seq1;
   } cfg_type;

   typedef struct packed {
      kind_type                   kind;
      logic [BYTE_W-1:0]          data_byte;
      logic                       frame_seq;
      logic                       reply_is_reject;
      logic                       reply_seq;
      logic [PAYLOAD_COUNT_W-1:0] payload_count;
   } result_type;

endpackage

>>> rtl/ifrd_csr.sv
module ifrd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ifrd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ifrd_pkg::BYTE_W-1:0]       csr_wdata,
   output ifrd_pkg::cfg_type                 cfg
);
   import ifrd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FLAG_BYTE:      cfg_in.flag_byte      = csr_wdata;
            CSR_ESCAPE_BYTE:    cfg_in.escape_byte    = csr_wdata;
            CSR_FLAG_ESC_CODE:  cfg_in.flag_esc_code  = csr_wdata;
            CSR_ESC_ESC_CODE:   cfg_in.esc_esc_code   = csr_wdata;
            CSR_ADDRESS_BYTE:   cfg_in.address_byte   = csr_wdata;
            CSR_INFO_CTRL_SEQ0: cfg_in.info_ctrl_seq0 = csr_wdata;
            CSR_INFO_CTRL_SEQ1: cfg_in.info_ctrl_seq1 = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte      <= FLAG_BYTE_RST;
         cfg_ff.escape_byte    <= ESCAPE_BYTE_RST;
         cfg_ff.flag_esc_code  <= FLAG_ESC_CODE_RST;
         cfg_ff.esc_esc_code   <= ESC_ESC_CODE_RST;
         cfg_ff.address_byte   <= ADDRESS_BYTE_RST;
         cfg_ff.info_ctrl_seq0 <= INFO_CTRL_SEQ0_RST;
         cfg_ff.info_ctrl_seq1 <= INFO_CTRL_SEQ1_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/ifrd_core.sv
module ifrd_core #(
   parameter int MAX_FRAME = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [ifrd_pkg::BYTE_W-1:0]  rx_byte,
   input  ifrd_pkg::cfg_type            cfg,
   output logic                         res_emit,
   output ifrd_pkg::result_type         res
);
   import ifrd_pkg::*;

   localparam int CntW = $clog2(MAX_FRAME + 1);
   localparam int ExtW = (CntW > PAYLOAD_COUNT_W) ? CntW : PAYLOAD_COUNT_W;

   frame_state_type    state_ff, state_in;
   logic               esc_ff, esc_in;
   logic               seq_ff, seq_in;
   logic               held_valid_ff, held_valid_in;
   logic [BYTE_W-1:0]  held_ff, held_in;
   logic [BYTE_W-1:0]  xor_ff, xor_in;
   logic [CntW-1:0]    count_ff, count_in;

   logic               flag_hit, esc_hit, fcode_hit, ecode_hit;
   logic               addr_hit, seq0_hit, seq1_hit, hdr_hit;
   logic               esc_bad, d_ok, ovf, check_ok;
   logic [BYTE_W-1:0]  ctrl_exp, d_val;
   logic [ExtW-1:0]    count_ext;

   assign flag_hit  = (rx_byte == cfg.flag_byte);
   assign esc_hit   = (rx_byte == cfg.escape_byte);
   assign fcode_hit = (rx_byte == cfg.flag_esc_code);
   assign ecode_hit = (rx_byte == cfg.esc_esc_code);
   assign addr_hit  = (rx_byte == cfg.address_byte);
   assign seq0_hit  = (rx_byte == cfg.info_ctrl_seq0);
   assign seq1_hit  = (rx_byte == cfg.info_ctrl_seq1);
   assign ctrl_exp  = seq_ff ? cfg.info_ctrl_seq1 : cfg.info_ctrl_seq0;
   assign hdr_hit   = (rx_byte == (cfg.address_byte ^ ctrl_exp));

   // destuffing decode; flag takes priority over a pending escape
   assign esc_bad  = esc_ff && !flag_hit && !fcode_hit && !ecode_hit;
   assign d_val    = !esc_ff ? rx_byte : (fcode_hit ? cfg.flag_byte : cfg.escape_byte);
   assign d_ok     = !flag_hit && !esc_bad && (esc_ff || !esc_hit);
   assign ovf      = d_ok && held_valid_ff && (count_ff >= CntW'(MAX_FRAME));
   assign check_ok = held_valid_ff && (held_ff == xor_ff);

   assign count_ext = ExtW'(count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_HUNT: state_in = flag_hit ? ST_FLAG : ST_HUNT;
         ST_FLAG: begin
            if (addr_hit)       state_in = ST_ADDR;
            else if (!flag_hit) state_in = ST_HUNT;
         end
         ST_ADDR: begin
            if (seq0_hit || seq1_hit) state_in = ST_CTRL;
            else                      state_in = flag_hit ? ST_FLAG : ST_HUNT;
         end
         ST_CTRL: begin
            if (hdr_hit) state_in = ST_INFO;
            else         state_in = flag_hit ? ST_FLAG : ST_HUNT;
         end
         ST_INFO: begin
            if (flag_hit || esc_bad || ovf) state_in = ST_HUNT;
         end
         default: state_in = flag_hit ? ST_FLAG : ST_HUNT;
      endcase
   end

   // datapath and result
   always_comb begin
      esc_in        = esc_ff;
      seq_in        = seq_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      xor_in        = xor_ff;
      count_in      = count_ff;
      res_emit      = 1'b0;
      res.kind            = KIND_DATA;
      res.data_byte       = '0;
      res.frame_seq       = seq_ff;
      res.reply_is_reject = 1'b0;
      res.reply_seq       = 1'b0;
      res.payload_count   = count_ext[PAYLOAD_COUNT_W-1:0];
      case (state_ff)
         ST_ADDR: begin
            if (seq0_hit)      seq_in = 1'b0;
            else if (seq1_hit) seq_in = 1'b1;
         end
         ST_CTRL: begin
            if (hdr_hit) begin
               esc_in        = 1'b0;
               held_valid_in = 1'b0;
               held_in       = '0;
               xor_in        = '0;
               count_in      = '0;
            end
         end
         ST_INFO: begin
            if (flag_hit) begin
               res_emit = 1'b1;
               esc_in   = 1'b0;
               if (esc_ff) begin
                  res.kind = KIND_ESC_ERROR;
               end else if (check_ok) begin
                  res.kind      = KIND_GOOD;
                  res.reply_seq = ~seq_ff;
               end else begin
                  res.kind            = KIND_BAD_CHECK;
                  res.reply_is_reject = 1'b1;
                  res.reply_seq       = seq_ff;
               end
            end else if (esc_bad) begin
               res_emit = 1'b1;
               esc_in   = 1'b0;
               res.kind = KIND_ESC_ERROR;
            end else if (!d_ok) begin
               esc_in = 1'b1;   // escape seen, wait for its code
            end else begin
               esc_in = 1'b0;
               if (!held_valid_ff) begin
                  held_in       = d_val;
                  held_valid_in = 1'b1;
               end else if (ovf) begin
                  res_emit = 1'b1;
                  res.kind = KIND_OVERFLOW;
               end else begin
                  // the held byte turns out not to be the check byte
                  res_emit      = 1'b1;
                  res.data_byte = held_ff;
                  xor_in        = xor_ff ^ held_ff;
                  count_in      = count_ff + CntW'(1);
                  held_in       = d_val;
               end
            end
         end
         default: ;
      endcase
      res_emit = res_emit && fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_HUNT;
         esc_ff        <= 1'b0;
         seq_ff        <= 1'b0;
         held_valid_ff <= 1'b0;
         held_ff       <= '0;
         xor_ff        <= '0;
         count_ff      <= '0;
      end else if (fire) begin
         state_ff      <= state_in;
         esc_ff        <= esc_in;
         seq_ff        <= seq_in;
         held_valid_ff <= held_valid_in;
         held_ff       <= held_in;
         xor_ff        <= xor_in;
         count_ff      <= count_in;
      end
   end

endmodule

>>> rtl/ifrd_rsp_reg.sv
module ifrd_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ifrd_pkg::result_type  res,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  free,
   output ifrd_pkg::result_type  rsp
);
   import ifrd_pkg::*;

   logic       valid_ff, valid_in;
   result_type rsp_ff;

   // register can take a new result when empty or being drained this cycle
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> rtl/info_frame_receiver_destuff_top.sv
// Channel   Dir  Handshake            Beat
// req_      in   req_valid/req_ready  rx_byte, one line byte
// rsp_      out  rsp_valid/rsp_ready  kind, data_byte, frame_seq, reply fields, count
// csr_      in   csr_we               csr_index, csr_wdata (no read-back)
//
// One byte per cycle while req_ready is high: frame state machine and destuffing
// feed the result register; a result is valid in the cycle after its byte's accept.
// req_ready drops only while a result sits in the register and rsp_ready is low.
// Synchronous active-high reset restores register defaults and hunting state.
module info_frame_receiver_destuff_top #(
   parameter int MAX_FRAME = 4096
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [ifrd_pkg::BYTE_W-1:0]             req_rx_byte,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [ifrd_pkg::KIND_W-1:0]             rsp_kind,
   output logic [ifrd_pkg::BYTE_W-1:0]             rsp_data_byte,
   output logic                                    rsp_frame_seq,
   output logic                                    rsp_reply_is_reject,
   output logic                                    rsp_reply_seq,
   output logic [ifrd_pkg::PAYLOAD_COUNT_W-1:0]    rsp_payload_count,
   input  logic                                    csr_we,
   input  logic [ifrd_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ifrd_pkg::BYTE_W-1:0]             csr_wdata
);
   import ifrd_pkg::*;

   cfg_type    cfg;
   result_type res;
   result_type rsp;
   logic       res_emit;
   logic       free;
   logic       fire;

   assign req_ready = free;
   assign fire      = req_valid && free;

   ifrd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ifrd_core #(
      .MAX_FRAME (MAX_FRAME)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .rx_byte  (req_rx_byte),
      .cfg      (cfg),
      .res_emit (res_emit),
      .res      (res)
   );

   ifrd_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (res_emit),
      .res       (res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .free      (free),
      .rsp       (rsp)
   );

   assign rsp_kind            = rsp.kind;
   assign rsp_data_byte       = rsp.data_byte;
   assign rsp_frame_seq       = rsp.frame_seq;
   assign rsp_reply_is_reject = rsp.reply_is_reject;
   assign rsp_reply_seq       = rsp.reply_seq;
   assign rsp_payload_count   = rsp.payload_count;

`ifndef SYNTHESIS
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_reject_only_on_bad_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reply_is_reject) |-> (rsp_kind == KIND_BAD_CHECK))
      else $error("REJ reported on a non check-bad result");

   a_data_zero_on_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_DATA)) |-> (rsp_data_byte == '0))
      else $error("data byte nonzero on a verdict");

   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid ##1 rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result appeared without an accepted byte");
`endif

endmodule

>>> dv/info_frame_receiver_destuff_top_tb.sv
module info_frame_receiver_destuff_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ifrd_pkg::*;

   // small frame limit so that overflow is reachable in a short run
   localparam int FRAME_LIMIT     = 16;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int CYCLE_LIMIT     = 100000;

   typedef enum logic [2:0] {
      RX_HUNT,
      RX_FLAG,
      RX_ADDR,
      RX_CTRL,
      RX_HDR,
      RX_INFO
   } rx_state_type;

   class frame_scoreboard;
      cfg_type      cfg;
      rx_state_type rx_state;
      bit           esc_pending;
      bit           frame_seq;
      logic [7:0]   held_byte;
      bit           held_ok;
      logic [7:0]   payload_xor;
      int unsigned  payload_count;
      int unsigned  max_frame;
      int unsigned  mismatches;
      result_type   frame_results[$];

      function new(int unsigned frame_limit);
         max_frame     = frame_limit;
         mismatches    = 0;
         cfg.flag_byte      = FLAG_BYTE_RST;
         cfg.escape_byte    = ESCAPE_BYTE_RST;
         cfg.flag_esc_code  = FLAG_ESC_CODE_RST;
         cfg.esc_esc_code   = ESC_ESC_CODE_RST;
         cfg.address_byte   = ADDRESS_BYTE_RST;
         cfg.info_ctrl_seq0 = INFO_CTRL_SEQ0_RST;
         cfg.info_ctrl_seq1 = INFO_CTRL_SEQ1_RST;
         rx_state      = RX_HUNT;
         esc_pending   = 1'b0;
         frame_seq     = 1'b0;
         held_byte     = '0;
         held_ok       = 1'b0;
         payload_xor   = '0;
         payload_count = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [7:0] val);
         case (idx)
            CSR_FLAG_BYTE:      cfg.flag_byte      = val;
            CSR_ESCAPE_BYTE:    cfg.escape_byte    = val;
            CSR_FLAG_ESC_CODE:  cfg.flag_esc_code  = val;
            CSR_ESC_ESC_CODE:   cfg.esc_esc_code   = val;
            CSR_ADDRESS_BYTE:   cfg.address_byte   = val;
            CSR_INFO_CTRL_SEQ0: cfg.info_ctrl_seq0 = val;
            CSR_INFO_CTRL_SEQ1: cfg.info_ctrl_seq1 = val;
            default: ;
         endcase
      endfunction

      function void queue_result(kind_type k, logic [7:0] d, logic rej, logic rseq);
         result_type r;
         r.kind            = k;
         r.data_byte       = d;
         r.frame_seq       = frame_seq;
         r.reply_is_reject = rej;
         r.reply_seq       = rseq;
         r.payload_count   = payload_count[PAYLOAD_COUNT_W-1:0];
         frame_results.push_back(r);
      endfunction

      function void abort_frame(kind_type k);
         rx_state    = RX_HUNT;
         esc_pending = 1'b0;
         queue_result(k, 8'h00, 1'b0, 1'b0);
      endfunction

      function void take_payload_byte(logic [7:0] b);
         logic [7:0] d;
         if (b == cfg.flag_byte) begin
            if (esc_pending) begin
               abort_frame(KIND_ESC_ERROR);
               return;
            end
            rx_state = RX_HUNT;
            if (held_ok && held_byte == payload_xor)
               queue_result(KIND_GOOD, 8'h00, 1'b0, ~frame_seq);
            else
               queue_result(KIND_BAD_CHECK, 8'h00, 1'b1, frame_seq);
            return;
         end
         if (esc_pending) begin
            if (b == cfg.flag_esc_code)
               d = cfg.flag_byte;
            else if (b == cfg.esc_esc_code)
               d = cfg.escape_byte;
            else begin
               // anything else after an escape, a second escape included
               abort_frame(KIND_ESC_ERROR);
               return;
            end
            esc_pending = 1'b0;
         end else if (b == cfg.escape_byte) begin
            esc_pending = 1'b1;
            return;
         end else begin
            d = b;
         end
         // one byte held back: the last one before the flag is the check
         if (!held_ok) begin
            held_byte = d;
            held_ok   = 1'b1;
            return;
         end
         if (payload_count >= max_frame) begin
            abort_frame(KIND_OVERFLOW);
            return;
         end
         queue_result(KIND_DATA, held_byte, 1'b0, 1'b0);
         payload_xor   = payload_xor ^ held_byte;
         payload_count = payload_count + 1;
         held_byte     = d;
      endfunction

      function void accept_line_byte(logic [7:0] b);
         logic [7:0] ctrl;
         ctrl = frame_seq ? cfg.info_ctrl_seq1 : cfg.info_ctrl_seq0;
         case (rx_state)
            RX_FLAG: begin
               if (b == cfg.address_byte)
                  rx_state = RX_ADDR;
               else if (b != cfg.flag_byte)
                  rx_state = RX_HUNT;
            end
            RX_ADDR: begin
               // equal control bytes: sequence 0 wins
               if (b == cfg.info_ctrl_seq0 || b == cfg.info_ctrl_seq1) begin
                  frame_seq = (b != cfg.info_ctrl_seq0);
                  rx_state  = RX_CTRL;
               end else begin
                  rx_state = (b == cfg.flag_byte) ? RX_FLAG : RX_HUNT;
               end
            end
            RX_CTRL: begin
               if (b == (cfg.address_byte ^ ctrl)) begin
                  rx_state      = RX_HDR;
                  esc_pending   = 1'b0;
                  held_byte     = '0;
                  held_ok       = 1'b0;
                  payload_xor   = '0;
                  payload_count = 0;
               end else begin
                  rx_state = (b == cfg.flag_byte) ? RX_FLAG : RX_HUNT;
               end
            end
            RX_HDR: begin
               if (b == cfg.flag_byte) begin
                  rx_state = RX_HUNT;
                  queue_result(KIND_BAD_CHECK, 8'h00, 1'b1, frame_seq);
               end else begin
                  rx_state = RX_INFO;
                  take_payload_byte(b);
               end
            end
            RX_INFO: take_payload_byte(b);
            default: rx_state = (b == cfg.flag_byte) ? RX_FLAG : RX_HUNT;
         endcase
      endfunction

      function void compare_field(string field, logic [12:0] want, logic [12:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_rsp_beat(result_type got);
         result_type want;
         if (frame_results.size() == 0) begin
            $error("rsp beat with nothing pending: kind %0d data 0x%0h", got.kind,
                   got.data_byte);
            mismatches++;
            return;
         end
         want = frame_results.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("data_byte", want.data_byte, got.data_byte);
         compare_field("frame_seq", want.frame_seq, got.frame_seq);
         compare_field("reply_is_reject", want.reply_is_reject, got.reply_is_reject);
         compare_field("reply_seq", want.reply_seq, got.reply_seq);
         compare_field("payload_count", want.payload_count, got.payload_count);
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [BYTE_W-1:0]          req_rx_byte;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [KIND_W-1:0]          rsp_kind;
   logic [BYTE_W-1:0]          rsp_data_byte;
   logic                       rsp_frame_seq;
   logic                       rsp_reply_is_reject;
   logic                       rsp_reply_seq;
   logic [PAYLOAD_COUNT_W-1:0] rsp_payload_count;
   logic                       csr_we;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [BYTE_W-1:0]          csr_wdata;

   frame_scoreboard sb;
   logic [7:0]      line_bytes[$];
   bit              hold_off_req;
   int unsigned     cycle_count = 0;

   info_frame_receiver_destuff_top #(
      .MAX_FRAME(FRAME_LIMIT)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_frame_seq      (rsp_frame_seq),
      .rsp_reply_is_reject(rsp_reply_is_reject),
      .rsp_reply_seq      (rsp_reply_seq),
      .rsp_payload_count  (rsp_payload_count),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type beat;
      if (!reset) begin
         if (req_valid && req_ready)
            sb.accept_line_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            beat.kind            = kind_type'(rsp_kind);
            beat.data_byte       = rsp_data_byte;
            beat.frame_seq       = rsp_frame_seq;
            beat.reply_is_reject = rsp_reply_is_reject;
            beat.reply_seq       = rsp_reply_seq;
            beat.payload_count   = rsp_payload_count;
            sb.check_rsp_beat(beat);
         end
      end
   end

   // rsp side: changing stall patterns, plus one long hold-off on request
   initial begin
      int unsigned ready_mode;
      int unsigned mode_left;
      bit          hold_done;
      ready_mode = 0;
      mode_left  = 0;
      hold_done  = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               ready_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(10, 60);
            end
            mode_left--;
            case (ready_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (mode_left % 3 != 0);
            endcase
         end
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void push_stuffed(logic [7:0] val, cfg_type c);
      if (val == c.flag_byte) begin
         line_bytes.push_back(c.escape_byte);
         line_bytes.push_back(c.flag_esc_code);
      end else if (val == c.escape_byte) begin
         line_bytes.push_back(c.escape_byte);
         line_bytes.push_back(c.esc_esc_code);
      end else begin
         line_bytes.push_back(val);
      end
   endfunction

   // payload values lean toward the flag and escape bytes and their codes
   function automatic logic [7:0] payload_value(cfg_type c);
      case ($urandom_range(0, 7))
         0:       return c.flag_byte;
         1:       return c.escape_byte;
         2:       return c.flag_esc_code;
         3:       return c.esc_esc_code;
         default: return rand_byte();
      endcase
   endfunction

   function automatic void add_random_frame();
      cfg_type     c;
      logic [7:0]  ctrl;
      logic [7:0]  chk;
      logic [7:0]  val;
      int unsigned flaw;
      int unsigned pick;
      int unsigned len;
      int unsigned bad_at;
      bit          seq;
      c = sb.cfg;
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) line_bytes.push_back(rand_byte());
      line_bytes.push_back(c.flag_byte);
      if ($urandom_range(0, 4) == 0)
         line_bytes.push_back(c.flag_byte);
      seq  = 1'($urandom_range(0, 1));
      ctrl = seq ? c.info_ctrl_seq1 : c.info_ctrl_seq0;
      flaw = $urandom_range(0, 99);
      line_bytes.push_back(flaw == 0 ? rand_byte() : c.address_byte);
      line_bytes.push_back(flaw == 1 ? rand_byte() : ctrl);
      line_bytes.push_back(flaw == 2 ? rand_byte() : c.address_byte ^ ctrl);
      pick = $urandom_range(0, 19);
      if (pick == 0)
         len = 0;
      else if (pick == 1)
         len = $urandom_range(FRAME_LIMIT - 1, FRAME_LIMIT + 3);
      else
         len = $urandom_range(1, 10);
      bad_at = (flaw >= 3 && flaw <= 8) ? $urandom_range(0, len) : len + 1;
      chk    = '0;
      for (int unsigned i = 0; i <= len; i++) begin
         if (i == bad_at) begin
            line_bytes.push_back(c.escape_byte);
            case ($urandom_range(0, 3))
               0, 1:    line_bytes.push_back(c.escape_byte);
               2:       line_bytes.push_back(c.flag_byte);
               default: line_bytes.push_back(rand_byte());
            endcase
         end
         if (i < len) begin
            val = payload_value(c);
            chk = chk ^ val;
            push_stuffed(val, c);
         end
      end
      if (len > 0)
         push_stuffed((flaw >= 9 && flaw <= 18) ? chk ^ (8'h01 << $urandom_range(0, 7)) : chk,
                      c);
      else if ($urandom_range(0, 1) == 0)
         push_stuffed(8'h00, c);   // lone check byte: good frame with no payload
      if (flaw != 19)
         line_bytes.push_back(c.flag_byte);
   endfunction

   function automatic cfg_type distinct_cfg();
      logic [7:0] v[7];
      cfg_type    c;
      bit         clash;
      for (int i = 0; i < 7; i++) begin
         do begin
            v[i]  = rand_byte();
            clash = 1'b0;
            for (int j = 0; j < i; j++)
               if (v[j] == v[i])
                  clash = 1'b1;
         end while (clash);
      end
      c.flag_byte      = v[0];
      c.escape_byte    = v[1];
      c.flag_esc_code  = v[2];
      c.esc_esc_code   = v[3];
      c.address_byte   = v[4];
      c.info_ctrl_seq0 = v[5];
      c.info_ctrl_seq1 = v[6];
      return c;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic apply_config(input cfg_type c);
      write_csr(CSR_FLAG_BYTE, c.flag_byte);
      write_csr(CSR_ESCAPE_BYTE, c.escape_byte);
      write_csr(CSR_FLAG_ESC_CODE, c.flag_esc_code);
      write_csr(CSR_ESC_ESC_CODE, c.esc_esc_code);
      write_csr(CSR_ADDRESS_BYTE, c.address_byte);
      write_csr(CSR_INFO_CTRL_SEQ0, c.info_ctrl_seq0);
      write_csr(CSR_INFO_CTRL_SEQ1, c.info_ctrl_seq1);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // req side: bursts of random length, random gaps, some runs gapless
   task automatic send_line_bytes();
      int unsigned burst;
      int unsigned gap;
      while (line_bytes.size() != 0) begin
         burst = $urandom_range(1, 24);
         while (burst != 0 && line_bytes.size() != 0) begin
            @(negedge clock);
            req_valid   <= 1'b1;
            req_rx_byte <= line_bytes.pop_front();
            do @(posedge clock); while (!req_ready);
            burst--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            @(negedge clock);
            req_valid   <= 1'b0;
            req_rx_byte <= rand_byte();
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned byte_budget);
      while (line_bytes.size() < byte_budget)
         add_random_frame();
      send_line_bytes();
      // idle until every pending result is out
      while (sb.frame_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      cfg_type     next_cfg;
      int unsigned drain;
      sb           = new(FRAME_LIMIT);
      hold_off_req = 1'b0;
      req_valid    = 1'b0;
      req_rx_byte  = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      reset        = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: header check as flag, empty frame, stuffed good frame,
      // double escape, flag after escape
      line_bytes = {
         FLAG_BYTE_RST, ADDRESS_BYTE_RST, INFO_CTRL_SEQ1_RST, FLAG_BYTE_RST,
         ADDRESS_BYTE_RST, INFO_CTRL_SEQ1_RST, ADDRESS_BYTE_RST ^ INFO_CTRL_SEQ1_RST,
         FLAG_BYTE_RST,
         FLAG_BYTE_RST, ADDRESS_BYTE_RST, INFO_CTRL_SEQ0_RST,
         ADDRESS_BYTE_RST ^ INFO_CTRL_SEQ0_RST,
         ESCAPE_BYTE_RST, FLAG_ESC_CODE_RST, ESCAPE_BYTE_RST, ESC_ESC_CODE_RST,
         8'h00, 8'hFF, FLAG_BYTE_RST ^ ESCAPE_BYTE_RST ^ 8'hFF, FLAG_BYTE_RST,
         FLAG_BYTE_RST, ADDRESS_BYTE_RST, INFO_CTRL_SEQ0_RST,
         ADDRESS_BYTE_RST ^ INFO_CTRL_SEQ0_RST, 8'h11, ESCAPE_BYTE_RST, ESCAPE_BYTE_RST,
         FLAG_BYTE_RST, ADDRESS_BYTE_RST, INFO_CTRL_SEQ0_RST,
         ADDRESS_BYTE_RST ^ INFO_CTRL_SEQ0_RST, ESCAPE_BYTE_RST, FLAG_BYTE_RST
      };
      run_phase(100);

      apply_config(distinct_cfg());
      hold_off_req = 1'b1;
      run_phase(85);

      next_cfg = '{flag_byte: 8'h00, escape_byte: 8'hFF, flag_esc_code: 8'hFF,
                   esc_esc_code: 8'h00, address_byte: 8'h00, info_ctrl_seq0: 8'h00,
                   info_ctrl_seq1: 8'hFF};
      apply_config(next_cfg);
      run_phase(75);

      next_cfg = '{flag_byte: 8'hFF, escape_byte: 8'h00, flag_esc_code: 8'h00,
                   esc_esc_code: 8'hFF, address_byte: 8'hFF, info_ctrl_seq0: 8'hFF,
                   info_ctrl_seq1: 8'h00};
      apply_config(next_cfg);
      run_phase(75);

      next_cfg = distinct_cfg();
      next_cfg.info_ctrl_seq1 = next_cfg.info_ctrl_seq0;
      apply_config(next_cfg);
      run_phase(85);

      apply_config(distinct_cfg());
      run_phase(85);

      drain = 0;
      while (sb.frame_results.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (sb.frame_results.size() != 0) begin
         $error("%0d predicted results never came out", sb.frame_results.size());
         sb.mismatches++;
      end
      if (sb.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
